@@ hdl/irrigation_cycle_sequencer_assert.svh @@
// Assertion macros shared by the sequencer RTL.
// All of them sample on aclk and are disabled while aresetn is low.
`ifndef IRRIGATION_CYCLE_SEQUENCER_ASSERT_SVH
`define IRRIGATION_CYCLE_SEQUENCER_ASSERT_SVH

// The condition must hold at every clock edge.
`define ICS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("sequencer assertion failed");

// When the antecedent holds, the consequent must hold at the next edge.
`define ICS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

@@ hdl/ics_pkg.sv @@
`default_nettype none

package ics_pkg;

    // Phase codes.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DOSE = 3'd1;
    localparam logic [2:0] PH_FILL = 3'd2;
    localparam logic [2:0] PH_PUMP = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;
    localparam logic [2:0] PH_ERR  = 3'd5;

    // Error codes.
    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_TOP     = 4'd1;
    localparam logic [3:0] ERR_BOTTOM  = 4'd2;
    localparam logic [3:0] ERR_FILL_TO = 4'd3;
    localparam logic [3:0] ERR_SENSOR  = 4'd6;
    localparam logic [3:0] ERR_CONFIG  = 4'd7;
    localparam logic [3:0] ERR_PUMP_TO = 4'd8;
    localparam logic [3:0] ERR_STOP    = 4'd9;

    // Command codes.
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_WASH  = 3'd2;
    localparam logic [2:0] ACT_STOP  = 3'd3;
    localparam logic [2:0] ACT_TRIP  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PPL       = 3'd0;
    localparam logic [2:0] CFG_IRR_VOL   = 3'd1;
    localparam logic [2:0] CFG_WASH_VOL  = 3'd2;
    localparam logic [2:0] CFG_DOSE_MS   = 3'd3;
    localparam logic [2:0] CFG_FILL_TO_S = 3'd4;
    localparam logic [2:0] CFG_PUMP_TO_S = 3'd5;

    // Field widths.
    localparam int PPL_W    = 24;
    localparam int VOL_W    = 20;
    localparam int TIME_W   = 16;
    localparam int TARGET_W = PPL_W + VOL_W;
    localparam int DOSE_W   = VOL_W + TIME_W - 8;
    localparam int LIMIT_W  = TIME_W + 10;
    localparam int MS_W     = 32;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    // Values derived from the configuration registers, ready for the step logic.
    typedef struct packed {
        logic                irr_bad;
        logic                wash_bad;
        logic [TARGET_W-1:0] irr_target;
        logic [TARGET_W-1:0] wash_target;
        logic [DOSE_W-1:0]   irr_dose_ms;
        logic [LIMIT_W-1:0]  fill_limit_ms;
        logic [LIMIT_W-1:0]  pump_limit_ms;
    } cfg_t;

endpackage

`default_nettype wire

@@ hdl/ics_cfg.sv @@
`default_nettype none

module ics_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [ics_pkg::PPL_W-1:0]  cfg_wdata,
    output ics_pkg::cfg_t                   cfg
);
    import ics_pkg::*;

    logic [PPL_W-1:0]    ppl_reg;
    logic [VOL_W-1:0]    irr_vol_reg;
    logic [VOL_W-1:0]    wash_vol_reg;
    logic [TIME_W-1:0]   dose_ms_reg;
    logic [TIME_W-1:0]   fill_to_reg;
    logic [TIME_W-1:0]   pump_to_reg;

    logic [TARGET_W-1:0] irr_target_reg;
    logic [TARGET_W-1:0] wash_target_reg;
    logic [DOSE_W-1:0]   irr_dose_reg;
    logic [LIMIT_W-1:0]  fill_limit_reg;
    logic [LIMIT_W-1:0]  pump_limit_reg;
    logic                irr_bad_reg;
    logic                wash_bad_reg;

    logic [VOL_W+TIME_W-1:0] dose_prod;

    // Register file, written one register per transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppl_reg      <= PPL_W'(256);
            irr_vol_reg  <= VOL_W'(256);
            wash_vol_reg <= VOL_W'(256);
            dose_ms_reg  <= '0;
            fill_to_reg  <= TIME_W'(60);
            pump_to_reg  <= TIME_W'(600);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PPL:       ppl_reg      <= cfg_wdata;
                CFG_IRR_VOL:   irr_vol_reg  <= cfg_wdata[VOL_W-1:0];
                CFG_WASH_VOL:  wash_vol_reg <= cfg_wdata[VOL_W-1:0];
                CFG_DOSE_MS:   dose_ms_reg  <= cfg_wdata[TIME_W-1:0];
                CFG_FILL_TO_S: fill_to_reg  <= cfg_wdata[TIME_W-1:0];
                CFG_PUMP_TO_S: pump_to_reg  <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign dose_prod = (VOL_W+TIME_W)'(irr_vol_reg) * (VOL_W+TIME_W)'(dose_ms_reg);

    // Each product sits alone between two registers; they follow the register
    // file in the next cycle.
    always_ff @(posedge aclk) begin
        irr_target_reg  <= TARGET_W'(irr_vol_reg) * TARGET_W'(ppl_reg);
        wash_target_reg <= TARGET_W'(wash_vol_reg) * TARGET_W'(ppl_reg);
        irr_dose_reg    <= dose_prod[VOL_W+TIME_W-1:8];
        fill_limit_reg  <= LIMIT_W'(fill_to_reg) * LIMIT_W'(MS_PER_S);
        pump_limit_reg  <= LIMIT_W'(pump_to_reg) * LIMIT_W'(MS_PER_S);
        irr_bad_reg     <= (ppl_reg == '0) || (irr_vol_reg == '0)
                           || (fill_to_reg == '0) || (pump_to_reg == '0);
        wash_bad_reg    <= (ppl_reg == '0) || (wash_vol_reg == '0)
                           || (fill_to_reg == '0) || (pump_to_reg == '0);
    end

    assign cfg.irr_bad       = irr_bad_reg;
    assign cfg.wash_bad      = wash_bad_reg;
    assign cfg.irr_target    = irr_target_reg;
    assign cfg.wash_target   = wash_target_reg;
    assign cfg.irr_dose_ms   = irr_dose_reg;
    assign cfg.fill_limit_ms = fill_limit_reg;
    assign cfg.pump_limit_ms = pump_limit_reg;

endmodule

`default_nettype wire

@@ hdl/irrigation_cycle_sequencer.sv @@
// An input transfer is captured in the input register and moves on to the
// result register, which drives m_tdata, once that one is empty or being drained.
// Throughput: one item per cycle while m_tready holds; the next-state logic
// between the input and result registers does the whole update in one pass.
// Configuration products are re-registered in the cycle after each write.
// Reset: aresetn is synchronous and active low; it returns the sequencer to
// idle with no error and restores the configuration defaults.
`default_nettype none

`include "irrigation_cycle_sequencer_assert.svh"

module irrigation_cycle_sequencer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Configuration write port.
    input  wire logic                       cfg_wr_en,
    input  wire logic [2:0]                 cfg_index,
    input  wire logic [ics_pkg::PPL_W-1:0]  cfg_wdata,
    // Input stream: action[2:0], trip_code[6:3], tank_full[7], tank_empty[8],
    // flow_pulses[16:9], now_ms[48:17], zero fill above.
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [55:0]                s_tdata,
    // Result stream: phase[2:0], error_code[6:3], valve_open[7], pump_on[8],
    // doser_on[9], wash_active[10], zero fill above.
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata
);
    import ics_pkg::*;

    cfg_t cfg;

    logic        in_valid_reg;
    logic [48:0] in_data_reg;
    logic        out_valid_reg;
    logic [10:0] out_data_reg;
    logic        advance;

    // Sequencer state.
    logic [2:0]          phase_reg;
    logic [3:0]          error_reg;
    logic [MS_W-1:0]     start_reg;
    logic [31:0]         pulse_total_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [DOSE_W-1:0]   dose_reg;
    logic                wash_reg;

    logic [2:0]          phase_next;
    logic [3:0]          error_next;
    logic [MS_W-1:0]     start_next;
    logic [31:0]         pulse_total_next;
    logic [TARGET_W-1:0] target_next;
    logic [DOSE_W-1:0]   dose_next;
    logic                wash_next;

    logic [2:0]      in_action;
    logic [3:0]      in_trip;
    logic            in_full;
    logic            in_empty;
    logic [7:0]      in_pulses;
    logic [MS_W-1:0] in_now;

    logic [32:0]     pulse_sum;
    logic [2:0]      phase_cmd;
    logic [MS_W-1:0] elapsed;
    logic            wash_sel;

    ics_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // An item moves from the input register to the result register when the
    // result register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[48:0];
        end
    end

    assign in_action = in_data_reg[2:0];
    assign in_trip   = in_data_reg[6:3];
    assign in_full   = in_data_reg[7];
    assign in_empty  = in_data_reg[8];
    assign in_pulses = in_data_reg[16:9];
    assign in_now    = in_data_reg[48:17];

    // One update: count the pulses, apply the command, then run the phase logic.
    always_comb begin
        pulse_sum        = {1'b0, pulse_total_reg} + 33'(in_pulses);
        phase_next       = phase_reg;
        error_next       = error_reg;
        start_next       = start_reg;
        pulse_total_next = pulse_sum[32] ? '1 : pulse_sum[31:0];
        target_next      = target_reg;
        dose_next        = dose_reg;
        wash_next        = wash_reg;
        wash_sel         = (in_action == ACT_WASH);

        // Commands; a start is honored only from idle.
        case (in_action)
            ACT_START, ACT_WASH: begin
                if (phase_reg == PH_IDLE) begin
                    if (wash_sel ? cfg.wash_bad : cfg.irr_bad) begin
                        phase_next = PH_ERR;
                        error_next = ERR_CONFIG;
                    end else if (in_full) begin
                        phase_next = PH_ERR;
                        error_next = ERR_TOP;
                    end else begin
                        wash_next   = wash_sel;
                        target_next = wash_sel ? cfg.wash_target : cfg.irr_target;
                        start_next  = in_now;
                        if (wash_sel) begin
                            dose_next        = '0;
                            phase_next       = PH_FILL;
                            pulse_total_next = '0;
                        end else begin
                            dose_next  = cfg.irr_dose_ms;
                            phase_next = PH_DOSE;
                        end
                    end
                end
            end
            ACT_STOP: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_ERR) begin
                    phase_next = PH_ERR;
                    error_next = ERR_STOP;
                end
            end
            ACT_TRIP: begin
                if (phase_reg != PH_ERR) begin
                    phase_next = PH_ERR;
                    error_next = (in_trip == ERR_NONE || in_trip > ERR_STOP) ?
                                 ERR_SENSOR : in_trip;
                end
            end
            default: ;
        endcase

        phase_cmd = phase_next;
        elapsed   = in_now - start_next;

        // Phase logic, evaluated once on the phase left by the command.
        case (phase_cmd)
            PH_DOSE: begin
                if (elapsed >= MS_W'(dose_next)) begin
                    phase_next       = PH_FILL;
                    start_next       = in_now;
                    pulse_total_next = '0;
                end
            end
            PH_FILL: begin
                if (in_full) begin
                    phase_next = PH_ERR;
                    error_next = ERR_TOP;
                end else if ({pulse_total_next, 16'd0} >= 48'(target_next)) begin
                    if (in_empty) begin
                        phase_next = PH_ERR;
                        error_next = ERR_BOTTOM;
                    end else begin
                        phase_next = PH_PUMP;
                        start_next = in_now;
                    end
                end else if (elapsed > MS_W'(cfg.fill_limit_ms)) begin
                    phase_next = PH_ERR;
                    error_next = ERR_FILL_TO;
                end
            end
            PH_PUMP: begin
                if (in_empty) begin
                    phase_next = PH_DONE;
                    start_next = in_now;
                end else if (elapsed > MS_W'(cfg.pump_limit_ms)) begin
                    phase_next = PH_ERR;
                    error_next = ERR_PUMP_TO;
                end
            end
            PH_DONE: begin
                phase_next = PH_IDLE;
                start_next = in_now;
            end
            default: ;
        endcase
    end

    // State advances together with the item that caused the update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            error_reg       <= ERR_NONE;
            start_reg       <= '0;
            pulse_total_reg <= '0;
            target_reg      <= '0;
            dose_reg        <= '0;
            wash_reg        <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            error_reg       <= error_next;
            start_reg       <= start_next;
            pulse_total_reg <= pulse_total_next;
            target_reg      <= target_next;
            dose_reg        <= dose_next;
            wash_reg        <= wash_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {wash_next,
                             phase_next == PH_DOSE,
                             phase_next == PH_PUMP,
                             phase_next == PH_FILL,
                             error_next,
                             phase_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_data_reg};

    // Only reset leaves the error phase.
    `ICS_ASSERT_NEXT(a_err_latched, phase_reg == PH_ERR, phase_reg == PH_ERR)
    // An error code is held exactly while in the error phase.
    `ICS_ASSERT_ALWAYS(a_err_code_match, (phase_reg == PH_ERR) == (error_reg != ERR_NONE))
    // State moves only with a transfer into the result register.
    `ICS_ASSERT_NEXT(a_state_hold, !advance,
                     $stable(phase_reg) && $stable(pulse_total_reg) && $stable(start_reg))

endmodule

`default_nettype wire

@@ sim/tb_irrigation_cycle_sequencer.sv @@
`default_nettype none

module tb_irrigation_cycle_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import ics_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;
    localparam int PHASE_ITEMS = 75;

    // One tank update as it travels on s_tdata, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [7:0]  flow_pulses;
        logic        tank_empty;
        logic        tank_full;
        logic [3:0]  trip_code;
        logic [2:0]  action;
    } tank_update_t;

    // One status word as it travels on m_tdata.
    typedef struct packed {
        logic       wash_active;
        logic       doser_on;
        logic       pump_on;
        logic       valve_open;
        logic [3:0] error_code;
        logic [2:0] phase;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    irrigation_cycle_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Settings as the sequencer should hold them.
    logic [23:0] ppl_q8;
    logic [19:0] irr_vol_q8;
    logic [19:0] wash_vol_q8;
    logic [15:0] dose_ms_per_l;
    logic [15:0] fill_limit_s;
    logic [15:0] pump_limit_s;

    // Expected sequencer state.
    logic [2:0]  seq_phase;
    logic [3:0]  seq_error;
    logic [31:0] seq_start_ms;
    logic [31:0] seq_pulses;
    logic [43:0] seq_target;
    logic [31:0] seq_dose_ms;
    logic        seq_wash;

    status_t     status_due_q[$];
    logic [31:0] clock_ms;
    int          mismatch_count = 0;
    int          result_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;

    // Latch the first fault; later faults leave the code alone.
    task automatic latch_fault(input logic [3:0] code);
        if (seq_phase != PH_ERR) begin
            seq_error = code;
            seq_phase = PH_ERR;
        end
    endtask

    task automatic move_to(input logic [2:0] ph, input logic [31:0] now);
        seq_phase = ph;
        seq_start_ms = now;
        if (ph == PH_FILL)
            seq_pulses = '0;
    endtask

    function automatic logic start_allowed(input logic wash);
        logic [19:0] vol;
        vol = wash ? wash_vol_q8 : irr_vol_q8;
        return ppl_q8 != 0 && vol != 0 && fill_limit_s != 0 && pump_limit_s != 0;
    endfunction

    // A start is checked for idle, then settings, then the top float.
    task automatic try_start(input logic wash, input logic full, input logic [31:0] now);
        logic [19:0] vol;
        logic [35:0] dose_prod;
        vol = wash ? wash_vol_q8 : irr_vol_q8;
        if (seq_phase == PH_IDLE) begin
            if (!start_allowed(wash)) begin
                latch_fault(ERR_CONFIG);
            end else if (full) begin
                latch_fault(ERR_TOP);
            end else begin
                seq_wash = wash;
                seq_target = 44'(vol) * 44'(ppl_q8);
                if (wash) begin
                    seq_dose_ms = '0;
                    move_to(PH_FILL, now);
                end else begin
                    dose_prod = 36'(vol) * 36'(dose_ms_per_l);
                    seq_dose_ms = 32'(dose_prod >> 8);
                    move_to(PH_DOSE, now);
                end
            end
        end
    endtask

    // Apply one tank update and work out the status word it produces.
    task automatic step_sequencer(input tank_update_t u, output status_t s);
        logic [31:0] elapsed;
        if (seq_pulses > 32'hFFFF_FFFF - 32'(u.flow_pulses))
            seq_pulses = 32'hFFFF_FFFF;
        else
            seq_pulses = seq_pulses + 32'(u.flow_pulses);

        case (u.action)
            ACT_START: try_start(1'b0, u.tank_full, u.now_ms);
            ACT_WASH:  try_start(1'b1, u.tank_full, u.now_ms);
            ACT_STOP: begin
                if (seq_phase != PH_IDLE)
                    latch_fault(ERR_STOP);
            end
            ACT_TRIP: begin
                if (u.trip_code == ERR_NONE || u.trip_code > ERR_STOP)
                    latch_fault(ERR_SENSOR);
                else
                    latch_fault(u.trip_code);
            end
            default: ;
        endcase

        elapsed = u.now_ms - seq_start_ms;
        case (seq_phase)
            PH_DOSE: begin
                if (elapsed >= seq_dose_ms)
                    move_to(PH_FILL, u.now_ms);
            end
            PH_FILL: begin
                if (u.tank_full) begin
                    latch_fault(ERR_TOP);
                end else if ({seq_pulses, 16'h0000} >= {4'h0, seq_target}) begin
                    if (u.tank_empty)
                        latch_fault(ERR_BOTTOM);
                    else
                        move_to(PH_PUMP, u.now_ms);
                end else if (elapsed > 32'(fill_limit_s) * 32'(MS_PER_S)) begin
                    latch_fault(ERR_FILL_TO);
                end
            end
            PH_PUMP: begin
                if (u.tank_empty)
                    move_to(PH_DONE, u.now_ms);
                else if (elapsed > 32'(pump_limit_s) * 32'(MS_PER_S))
                    latch_fault(ERR_PUMP_TO);
            end
            PH_DONE: move_to(PH_IDLE, u.now_ms);
            default: ;
        endcase

        s.phase       = seq_phase;
        s.error_code  = seq_error;
        s.valve_open  = (seq_phase == PH_FILL);
        s.pump_on     = (seq_phase == PH_PUMP);
        s.doser_on    = (seq_phase == PH_DOSE);
        s.wash_active = seq_wash;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch on result %0d: %s is %0d, expected %0d",
                     result_count, what, got, want);
    endtask

    // Offer one update after a random gap and record its expected status on transfer.
    task automatic send_update(input tank_update_t u);
        status_t s;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, u};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        step_sequencer(u, s);
        status_due_q.push_back(s);
        clock_ms = u.now_ms;
    endtask

    task automatic send_cmd(input logic [2:0] action, input logic full, input logic empty,
                            input logic [7:0] pulses, input logic [31:0] now);
        tank_update_t u;
        u.action      = action;
        u.trip_code   = 4'($urandom_range(15));
        u.tank_full   = full;
        u.tank_empty  = empty;
        u.flow_pulses = pulses;
        u.now_ms      = now;
        send_update(u);
    endtask

    // Stop offering and wait until every expected status has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [23:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_PPL:       ppl_q8        = value;
            CFG_IRR_VOL:   irr_vol_q8    = value[19:0];
            CFG_WASH_VOL:  wash_vol_q8   = value[19:0];
            CFG_DOSE_MS:   dose_ms_per_l = value[15:0];
            CFG_FILL_TO_S: fill_limit_s  = value[15:0];
            CFG_PUMP_TO_S: pump_limit_s  = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_settings(input logic [23:0] ppl, input logic [19:0] irr,
                                  input logic [19:0] wash, input logic [15:0] dose,
                                  input logic [15:0] fill_s, input logic [15:0] pump_s);
        wait_drained();
        write_setting(CFG_PPL, ppl);
        write_setting(CFG_IRR_VOL, 24'(irr));
        write_setting(CFG_WASH_VOL, 24'(wash));
        write_setting(CFG_DOSE_MS, 24'(dose));
        write_setting(CFG_FILL_TO_S, 24'(fill_s));
        write_setting(CFG_PUMP_TO_S, 24'(pump_s));
        // Derived products settle in the cycle after the last write.
        repeat (3) @(posedge aclk);
    endtask

    // Build an update that keeps the sequencer out of the error phase.
    task automatic make_healthy_update(output tank_update_t u);
        int unsigned pick;
        logic [31:0] elapsed;
        logic [31:0] limit;
        logic [31:0] room;
        pick = $urandom_range(99);
        elapsed = clock_ms - seq_start_ms;
        u.trip_code   = 4'($urandom_range(15));
        u.tank_full   = 1'($urandom_range(1));
        u.tank_empty  = 1'($urandom_range(1));
        u.flow_pulses = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        u.action      = ($urandom_range(3) == 0) ? 3'($urandom_range(7, 5)) : ACT_TICK;
        u.now_ms      = clock_ms + 32'($urandom_range(300));
        if (seq_phase != PH_IDLE && pick < 15)
            u.action = ($urandom_range(1) == 0) ? ACT_START : ACT_WASH;
        case (seq_phase)
            PH_IDLE: begin
                if (pick < 35)
                    u.action = ACT_START;
                else if (pick < 55)
                    u.action = ACT_WASH;
                else if (pick < 65)
                    u.action = ACT_STOP;
                if ((u.action == ACT_START && !start_allowed(1'b0)) ||
                    (u.action == ACT_WASH && !start_allowed(1'b1)))
                    u.action = ACT_TICK;
                if (u.action == ACT_START || u.action == ACT_WASH)
                    u.tank_full = 1'b0;
                case ($urandom_range(9))
                    0: u.now_ms = $urandom;
                    1: u.now_ms = 32'hFFFF_FFFF - 32'($urandom_range(2000));
                    default: ;
                endcase
            end
            PH_DOSE: begin
                case ($urandom_range(5))
                    0, 1: u.now_ms = seq_start_ms + seq_dose_ms;
                    2:    u.now_ms = seq_start_ms + seq_dose_ms - 32'd1;
                    3:    u.now_ms = $urandom;
                    default: ;
                endcase
            end
            PH_FILL, PH_PUMP: begin
                if (seq_phase == PH_FILL) begin
                    u.tank_full  = 1'b0;
                    u.tank_empty = 1'b0;
                    limit = 32'(fill_limit_s) * 32'(MS_PER_S);
                end else begin
                    u.tank_empty = ($urandom_range(3) == 0);
                    limit = 32'(pump_limit_s) * 32'(MS_PER_S);
                end
                room = limit - elapsed;
                if ($urandom_range(7) == 0)
                    u.now_ms = clock_ms + room;
                else
                    u.now_ms = clock_ms + 32'($urandom_range((room < 32'd800) ? room : 32'd800));
            end
            default: begin
                if ($urandom_range(3) == 0)
                    u.now_ms = $urandom;
            end
        endcase
    endtask

    // Any update at all, used to build a trip and after the fault.
    function automatic tank_update_t make_any_update();
        tank_update_t u;
        u.action      = 3'($urandom_range(7));
        u.trip_code   = 4'($urandom_range(15));
        u.tank_full   = 1'($urandom_range(1));
        u.tank_empty  = 1'($urandom_range(1));
        u.flow_pulses = 8'($urandom_range(255));
        u.now_ms      = $urandom;
        return u;
    endfunction

    // Receiver: random stalls, or a long hold-off while hold_left runs down.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each status transfer with the oldest expected status.
    always @(posedge aclk) begin
        status_t got;
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_t'(m_tdata[10:0]);
            if (status_due_q.size() == 0) begin
                report_mismatch("unexpected status word", longint'(m_tdata), 0);
            end else begin
                want = status_due_q.pop_front();
                if (got.phase != want.phase)
                    report_mismatch("phase", got.phase, want.phase);
                if (got.error_code != want.error_code)
                    report_mismatch("error_code", got.error_code, want.error_code);
                if (got.valve_open != want.valve_open)
                    report_mismatch("valve_open", got.valve_open, want.valve_open);
                if (got.pump_on != want.pump_on)
                    report_mismatch("pump_on", got.pump_on, want.pump_on);
                if (got.doser_on != want.doser_on)
                    report_mismatch("doser_on", got.doser_on, want.doser_on);
                if (got.wash_active != want.wash_active)
                    report_mismatch("wash_active", got.wash_active, want.wash_active);
            end
            result_count <= result_count + 1;
        end
    end

    // Watchdog on cycles in which neither side moves a transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[irrigation_cycle_sequencer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A wash cycle on reset settings, with a stop and an unused code in idle.
    task automatic test_default_wash_cycle();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd3, 32'd100);
        send_cmd(ACT_STOP, 1'b1, 1'b0, 8'd0, 32'd110);
        send_cmd(3'd7, 1'b0, 1'b1, 8'd255, 32'd120);
        send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd9, 32'd200);
        // Elapsed equal to the fill limit does not trip the timeout.
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, 32'd60200);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd1, 32'd60201);
        send_cmd(ACT_START, 1'b0, 1'b0, 8'd0, 32'd60300);
        send_cmd(ACT_TICK, 1'b0, 1'b1, 8'd0, 32'd60400);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, 32'd60500);
    endtask

    // Cycles at the largest and smallest settings, across the time wrap.
    task automatic test_extreme_settings();
        logic [31:0] t0;
        apply_settings(24'hFF_FFFF, 20'd1, 20'hF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        t0 = 32'hFFFF_FF80;
        send_cmd(ACT_START, 1'b0, 1'b0, 8'd255, t0);
        send_cmd(ACT_TICK, 1'b1, 1'b0, 8'd10, t0 + 32'd254);
        // Pulses of the item that enters filling are dropped with the count.
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd200, t0 + 32'd255);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd255, t0 + 32'd300);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd1, t0 + 32'd400);
        send_cmd(ACT_TICK, 1'b0, 1'b1, 8'd0, t0 + 32'd500);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, t0 + 32'd600);

        // Zero dose time ends dosing in the item that starts it.
        apply_settings(24'd1, 20'hF_FFFF, 20'hF_FFFF, 16'd0, 16'd1, 16'd1);
        t0 = 32'd5000;
        send_cmd(ACT_START, 1'b0, 1'b0, 8'd77, t0);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd255, t0 + 32'd1000);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, t0 + 32'd2000);
        send_cmd(ACT_TICK, 1'b0, 1'b1, 8'd0, t0 + 32'd2100);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, t0 + 32'd2200);
        send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd0, t0 + 32'd3000);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd15, t0 + 32'd3100);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd1, t0 + 32'd3200);
        send_cmd(ACT_TICK, 1'b0, 1'b1, 8'd0, t0 + 32'd3300);
        send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, t0 + 32'd3400);
    endtask

    // Healthy random cycles over several settings and idling patterns.
    task automatic test_random_cycles();
        tank_update_t u;
        logic [23:0] ppl;
        logic [19:0] irr;
        logic [19:0] wash;
        logic [15:0] dose;
        logic [15:0] fill_s;
        logic [15:0] pump_s;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    ppl  = 24'($urandom_range(2048, 1));
                    irr  = 20'($urandom_range(2048, 1));
                    wash = 20'($urandom_range(2048, 1));
                end
                1: begin
                    ppl  = 24'hFF_FFFF;
                    irr  = 20'($urandom_range(4, 1));
                    wash = 20'($urandom_range(4, 1));
                end
                2: begin
                    ppl  = 24'($urandom_range(16, 1));
                    irr  = 20'hF_FFFF - 20'($urandom_range(1000));
                    wash = 20'($urandom_range(20'hF_FFFF, 1));
                end
                default: begin
                    ppl  = 24'($urandom_range(1024, 1));
                    irr  = 20'($urandom_range(1024, 1));
                    wash = 20'($urandom_range(1024, 1));
                    if ($urandom_range(1) == 0)
                        irr = '0;
                    else
                        wash = '0;
                end
            endcase
            dose   = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(16'hFFFF));
            fill_s = (ph % 4 == 3) ? 16'hFFFF : 16'($urandom_range(10, 1));
            pump_s = (ph % 4 == 3) ? 16'hFFFF : 16'($urandom_range(10, 1));
            // A timeout may not shrink under a cycle that is already running.
            if (seq_phase == PH_FILL)
                fill_s = fill_limit_s;
            if (seq_phase == PH_PUMP)
                pump_s = pump_limit_s;
            apply_settings(ppl, irr, wash, dose, fill_s, pump_s);

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while updates keep coming.
                if (ph == 0 && n == 20)
                    hold_left = 400;
                // Sender pause until every status has come back.
                if (ph == 1 && n == 40)
                    wait_drained();
                make_healthy_update(u);
                send_update(u);
            end
        end
    endtask

    // Drive one randomly chosen fault, then check that the first error stays.
    task automatic test_fault_latch();
        tank_update_t u;
        int unsigned scenario;
        int unsigned which;
        send_idle_pct = 19;
        recv_stall_pct = 19;
        // Finish the running cycle under the settings it started with.
        while (seq_phase != PH_IDLE) begin
            make_healthy_update(u);
            send_update(u);
        end
        apply_settings(24'd256, 20'd256, 20'd256, 16'd100, 16'd2, 16'd2);
        scenario = $urandom_range(7);
        case (scenario)
            0: begin
                which = $urandom_range(4);
                wait_drained();
                case (which)
                    0: write_setting(CFG_PPL, 24'd0);
                    1: write_setting(CFG_IRR_VOL, 24'd0);
                    2: write_setting(CFG_WASH_VOL, 24'd0);
                    3: write_setting(CFG_FILL_TO_S, 24'd0);
                    default: write_setting(CFG_PUMP_TO_S, 24'd0);
                endcase
                repeat (3) @(posedge aclk);
                send_cmd((which == 2) ? ACT_WASH : ACT_START, 1'b0, 1'b0, 8'd0,
                         clock_ms + 32'd10);
            end
            1: send_cmd(($urandom_range(1) == 0) ? ACT_START : ACT_WASH, 1'b1, 1'b0,
                        8'd0, clock_ms + 32'd10);
            2: begin
                send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                send_cmd(ACT_TICK, 1'b1, 1'b0, 8'd0, clock_ms + 32'd10);
            end
            3: begin
                send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                send_cmd(ACT_TICK, 1'b0, 1'b1, 8'd255, clock_ms + 32'd10);
            end
            4: begin
                // Largest fill target; it cannot be reached before the timeout.
                wait_drained();
                write_setting(CFG_PPL, 24'hFF_FFFF);
                write_setting(CFG_WASH_VOL, 24'h0F_FFFF);
                repeat (3) @(posedge aclk);
                send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd255, clock_ms + 32'd1000);
                send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd255, clock_ms + 32'd1000);
                send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd255, clock_ms + 32'd1);
            end
            5: begin
                send_cmd(ACT_WASH, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd1, clock_ms + 32'd10);
                send_cmd(ACT_TICK, 1'b0, 1'b0, 8'd0, clock_ms + 32'd2001);
            end
            6: begin
                send_cmd(ACT_START, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                for (int n = $urandom_range(4); n > 0; n--) begin
                    make_healthy_update(u);
                    send_update(u);
                end
                send_cmd(ACT_STOP, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
            end
            default: begin
                if ($urandom_range(1) == 0)
                    send_cmd(ACT_START, 1'b0, 1'b0, 8'd0, clock_ms + 32'd10);
                u = make_any_update();
                u.action = ACT_TRIP;
                send_update(u);
            end
        endcase
        // Everything after the fault, including further faults, must leave the code.
        for (int n = 0; n < 25; n++)
            send_update(make_any_update());
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;

        ppl_q8        = 24'd256;
        irr_vol_q8    = 20'd256;
        wash_vol_q8   = 20'd256;
        dose_ms_per_l = 16'd0;
        fill_limit_s  = 16'd60;
        pump_limit_s  = 16'd600;
        seq_phase     = PH_IDLE;
        seq_error     = ERR_NONE;
        seq_start_ms  = '0;
        seq_pulses    = '0;
        seq_target    = '0;
        seq_dose_ms   = '0;
        seq_wash      = 1'b0;
        clock_ms      = '0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_wash_cycle();
        test_extreme_settings();
        test_random_cycles();
        test_fault_latch();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (status_due_q.size() != 0)
            report_mismatch("statuses never returned", status_due_q.size(), 0);
        if (mismatch_count == 0)
            $display("[irrigation_cycle_sequencer] OK");
        else
            $display("[irrigation_cycle_sequencer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
